>>> src/deq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
// no dependencies

package deq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int OPCODE_W      = 3;
  localparam int DATA_W        = 64;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FRONT      = 3'd4,
    OP_BACK       = 3'd5,
    OP_SIZE       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming operation
    logic exec;     // apply the operation to store and pointers
    logic load;     // move the result into the output register
  } cmd_t;

endpackage

>>> src/deq_in_if.sv
`timescale 1ns / 1ps
// operation channel: valid/ready with opcode and push value
// depends on deq_pkg

interface deq_in_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::OPCODE_W-1:0]      opcode;
  logic signed [deq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

>>> src/deq_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready with status, data value and count
// depends on deq_pkg

interface deq_out_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::STATUS_W-1:0]      status;
  logic signed [deq_pkg::DATA_W-1:0] data_value;
  logic [deq_pkg::COUNT_W-1:0]       count;

  modport source (output valid, output status, output data_value, output count, input ready);
  modport sink (input valid, input status, input data_value, input count, output ready);
endinterface

>>> src/deq_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller: capture, execute, result load
// depends on deq_pkg

module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.load    = (state == S_LOAD) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/deq_datapath.sv
`timescale 1ns / 1ps
// ring buffer store, head and count registers, result register
// depends on deq_pkg

module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  deq_pkg::cmd_t                       cmd,
  input  logic [deq_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_push_value,
  output logic [deq_pkg::STATUS_W-1:0]        res_status,
  output logic signed [deq_pkg::DATA_W-1:0]   res_data_value,
  output logic [deq_pkg::COUNT_W-1:0]         res_count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  deq_pkg::op_t               op;
  logic [deq_pkg::DATA_W-1:0] value;
  logic [PTR_W-1:0]           head;
  logic [CNT_W-1:0]           count;
  deq_pkg::status_t           status_r;
  logic                       has_data;
  logic [deq_pkg::DATA_W-1:0] rd_data;

  logic [PTR_W-1:0]           head_next;
  logic [CNT_W-1:0]           count_next;
  deq_pkg::status_t           status_next;
  logic                       has_data_next;
  logic                       we;
  logic [PTR_W-1:0]           addr;
  logic [CNT_W-1:0]           offset;
  logic [SUM_W-1:0]           sum;
  logic [SUM_W-1:0]           pos;
  logic [PTR_W-1:0]           head_dec;
  logic                       empty;
  logic                       full;
  logic [CNT_W+deq_pkg::COUNT_W-1:0] cnt_wide;

  assign empty    = (count == '0);
  assign full     = (count == DEPTH_C);
  assign head_dec = (head == '0) ? LAST_P : head - PTR_W'(1);

  // ring position head + offset, wrapped once
  always_comb begin
    unique case (op)
      deq_pkg::OP_PUSH_BACK: offset = count;
      deq_pkg::OP_POP_BACK,
      deq_pkg::OP_BACK:      offset = count - CNT_W'(1);
      default:               offset = '0;
    endcase
    sum = SUM_W'(head) + SUM_W'(offset);
    pos = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
  end

  always_comb begin
    head_next     = head;
    count_next    = count;
    status_next   = deq_pkg::ST_OK;
    has_data_next = 1'b0;
    we            = 1'b0;
    addr          = pos[PTR_W-1:0];
    unique case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        addr = head_dec;
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          has_data_next = 1'b1;
          if (op == deq_pkg::OP_POP_FRONT) begin
            head_next  = (head == LAST_P) ? '0 : head + PTR_W'(1);
            count_next = count - CNT_W'(1);
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          has_data_next = 1'b1;
          if (op == deq_pkg::OP_POP_BACK) count_next = count - CNT_W'(1);
        end
      end
      deq_pkg::OP_SIZE: begin
      end
      deq_pkg::OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // operation capture and per-item result bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= deq_pkg::op_t'(in_opcode);
      value <= in_push_value;
    end
    if (cmd.exec) begin
      status_r <= status_next;
      has_data <= has_data_next;
    end
  end

  // single-port store, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) mem[addr] <= value;
      rd_data <= mem[addr];
    end
  end

  // count is reported in 11 bits
  assign cnt_wide = {{deq_pkg::COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status     <= status_r;
      res_data_value <= has_data ? rd_data : '0;
      res_count      <= cnt_wide[deq_pkg::COUNT_W-1:0];
    end
  end

endmodule

>>> src/double_ended_queue_core.sv
`timescale 1ns / 1ps
// double-ended queue of signed 64-bit values on a ring buffer
// depends on deq_pkg, deq_in_if, deq_out_if, deq_ctrl, deq_datapath
//
//  channel  dir  handshake      payload
//  in_ch    in   valid / ready  opcode[2:0], push_value[63:0] signed
//  out_ch   out  valid / ready  status[1:0], data_value[63:0] signed, count[10:0]
//
// one result per operation; each item passes through capture, one store access and
// result load in turn, as set by the single store port and the registered read; its
// result then sits in the output register until it is taken on out_ch
// the next operation is taken while a result still waits on out_ch; only the
// result load waits for the output register to drain
// synchronous active-high reset clears the controller, head and count; the
// store itself is not cleared, and clear only resets head and count

module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_pkg::cmd_t cmd;
  logic          in_ready;
  logic          out_valid;

  // sequencer: one operation in flight
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // store, pointers and output register
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_opcode      (in_ch.opcode),
    .in_push_value  (in_ch.push_value),
    .res_status     (out_ch.status),
    .res_data_value (out_ch.data_value),
    .res_count      (out_ch.count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // after an input transfer, ready stays low while that operation is in flight
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while previous operation in flight");

  // errors never carry data
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != deq_pkg::ST_OK) |-> (out_ch.data_value == '0))
    else $error("error result with nonzero data");

  // full refusal only when the ring is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == deq_pkg::ST_FULL && DEPTH < 2048)
      |-> (out_ch.count == DEPTH))
    else $error("full status with count below depth");

  // empty error only when nothing is stored
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == deq_pkg::ST_EMPTY) |-> (out_ch.count == '0))
    else $error("empty status with nonzero count");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for double_ended_queue_core: directed and random deque operations
// depends on deq_pkg, deq_in_if, deq_out_if and the double_ended_queue_core rtl

module testbench;

  localparam int DEPTH  = deq_pkg::DEPTH_DEFAULT;
  localparam int HEAD_W = $clog2(DEPTH);

  // one operation as offered on the input channel
  typedef struct {
    deq_pkg::op_t                      op;
    logic signed [deq_pkg::DATA_W-1:0] value;
  } deq_request_t;

  // one predicted result, tagged with the operation that caused it
  typedef struct {
    deq_pkg::op_t                      op;
    deq_pkg::status_t                  status;
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic [deq_pkg::COUNT_W-1:0]       count;
  } deq_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_results = 1'b0;

  deq_in_if  in_ch();
  deq_out_if out_ch();

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // operations waiting to be offered, and results still owed by the block
  deq_request_t op_backlog[$];
  deq_answer_t  answers_due[$];

  // shadow deque used to predict every result
  logic signed [deq_pkg::DATA_W-1:0] ring_mem[DEPTH];
  logic [HEAD_W-1:0]                 ring_head = '0;
  logic [deq_pkg::COUNT_W-1:0]       live_count = '0;

  int unsigned mismatches   = 0;
  int unsigned ops_sent     = 0;
  int unsigned results_seen = 0;

  // rough occupancy seen by the stimulus generator, only used to steer it
  int gen_live = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // apply one operation to the shadow deque and return what the block must answer
  function automatic deq_answer_t apply_deq_op(input deq_request_t req);
    deq_answer_t       ans;
    logic [HEAD_W-1:0] slot;
    ans.op     = req.op;
    ans.status = deq_pkg::ST_OK;
    ans.data   = '0;
    case (req.op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (live_count >= DEPTH) begin
          ans.status = deq_pkg::ST_FULL;
        end else begin
          if (req.op == deq_pkg::OP_PUSH_FRONT) begin
            // head steps back one place, wrapping below zero
            ring_head = HEAD_W'((int'(ring_head) + DEPTH - 1) % DEPTH);
            slot      = ring_head;
          end else begin
            slot = HEAD_W'((int'(ring_head) + int'(live_count)) % DEPTH);
          end
          ring_mem[slot] = req.value;
          live_count++;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_FRONT: begin
        if (live_count == 0) begin
          ans.status = deq_pkg::ST_EMPTY;
        end else begin
          ans.data = ring_mem[ring_head];
          if (req.op == deq_pkg::OP_POP_FRONT) begin
            ring_head = HEAD_W'((int'(ring_head) + 1) % DEPTH);
            live_count--;
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_BACK: begin
        if (live_count == 0) begin
          ans.status = deq_pkg::ST_EMPTY;
        end else begin
          slot     = HEAD_W'((int'(ring_head) + int'(live_count) - 1) % DEPTH);
          ans.data = ring_mem[slot];
          if (req.op == deq_pkg::OP_POP_BACK) live_count--;
        end
      end
      deq_pkg::OP_SIZE: begin
      end
      default: begin
        // clear: head and count only, stored words stay as they are
        ring_head  = '0;
        live_count = '0;
      end
    endcase
    ans.count = live_count;
    return ans;
  endfunction

  // queue one operation for the driver and keep the generator's occupancy estimate
  task automatic queue_op(input deq_pkg::op_t op,
                          input logic signed [deq_pkg::DATA_W-1:0] value);
    deq_request_t req;
    req.op    = op;
    req.value = value;
    op_backlog.insert(op_backlog.size(), req);
    case (op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: if (gen_live < DEPTH) gen_live++;
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   if (gen_live > 0) gen_live--;
      deq_pkg::OP_CLEAR:                             gen_live = 0;
      default: begin
      end
    endcase
  endtask

  // push value: mostly random, sometimes one of the extremes
  function automatic logic signed [deq_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
      1:       return {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // weighted pick of an operation; the rest after pushes, pops and clears are peeks and size
  function automatic deq_pkg::op_t choose_op(input int push_pct, input int pop_pct,
                                             input int clear_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct)
      return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    if (r < push_pct + pop_pct)
      return $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    if (r < push_pct + pop_pct + clear_pct) return deq_pkg::OP_CLEAR;
    case ($urandom_range(2))
      0:       return deq_pkg::OP_FRONT;
      1:       return deq_pkg::OP_BACK;
      default: return deq_pkg::OP_SIZE;
    endcase
  endfunction

  // blocks until nothing is queued, offered or owed; sampled away from the active edge
  task automatic wait_drained();
    @(negedge clk);
    while (op_backlog.size() != 0 || in_ch.valid || answers_due.size() != 0) @(negedge clk);
  endtask

  // driver: offers the oldest queued operation, idles at random except in a steady window
  deq_request_t offered;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid      <= 1'b0;
      in_ch.opcode     <= deq_pkg::OP_SIZE;
      in_ch.push_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        answers_due.insert(answers_due.size(), apply_deq_op(offered));
        ops_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (op_backlog.size() != 0 &&
            ((ops_sent >= 200 && ops_sent < 600) || $urandom_range(99) >= 20)) begin
          offered = op_backlog[0];
          op_backlog.delete(0);
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= offered.op;
          in_ch.push_value <= offered.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    deq_answer_t exp;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          flag_mismatch("result transfer with no operation outstanding");
        end else begin
          exp = answers_due[0];
          answers_due.delete(0);
          if (out_ch.status !== exp.status)
            flag_mismatch($sformatf("%s status %0d, expected %0d",
                                    exp.op.name(), out_ch.status, exp.status));
          if (out_ch.data_value !== exp.data)
            flag_mismatch($sformatf("%s data 0x%h, expected 0x%h",
                                    exp.op.name(), out_ch.data_value, exp.data));
          if (out_ch.count !== exp.count)
            flag_mismatch($sformatf("%s count %0d, expected %0d",
                                    exp.op.name(), out_ch.count, exp.count));
        end
      end
      out_ch.ready <= !hold_results &&
                      ((results_seen >= 200 && results_seen < 600) || $urandom_range(99) >= 20);
    end
  end

  // long hold-off on the result side while operations keep coming, so the block backs up
  initial begin
    while (results_seen < 1400) @(posedge clk);
    hold_results <= 1'b1;
    repeat (400) @(posedge clk);
    hold_results <= 1'b0;
  end

  // main sequence
  initial begin
    int mode;
    int seg_len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: every pop, peek and size on an empty deque, the value extremes, head wrap on
    // push front from reset, and clear followed by reads of an empty deque
    queue_op(deq_pkg::OP_POP_FRONT, rand_word());
    queue_op(deq_pkg::OP_POP_BACK, rand_word());
    queue_op(deq_pkg::OP_FRONT, rand_word());
    queue_op(deq_pkg::OP_BACK, rand_word());
    queue_op(deq_pkg::OP_SIZE, rand_word());
    queue_op(deq_pkg::OP_PUSH_FRONT, {1'b1, {(deq_pkg::DATA_W-1){1'b0}}});
    queue_op(deq_pkg::OP_PUSH_BACK, {1'b0, {(deq_pkg::DATA_W-1){1'b1}}});
    queue_op(deq_pkg::OP_PUSH_BACK, '1);
    queue_op(deq_pkg::OP_PUSH_FRONT, '0);
    queue_op(deq_pkg::OP_FRONT, rand_word());
    queue_op(deq_pkg::OP_BACK, rand_word());
    queue_op(deq_pkg::OP_SIZE, rand_word());
    queue_op(deq_pkg::OP_POP_BACK, rand_word());
    queue_op(deq_pkg::OP_POP_FRONT, rand_word());
    queue_op(deq_pkg::OP_CLEAR, rand_word());
    queue_op(deq_pkg::OP_POP_FRONT, rand_word());
    queue_op(deq_pkg::OP_BACK, rand_word());
    queue_op(deq_pkg::OP_PUSH_FRONT, {(deq_pkg::DATA_W/2){2'b10}});
    queue_op(deq_pkg::OP_PUSH_BACK, {(deq_pkg::DATA_W/2){2'b01}});
    queue_op(deq_pkg::OP_BACK, rand_word());
    queue_op(deq_pkg::OP_POP_FRONT, rand_word());
    queue_op(deq_pkg::OP_POP_BACK, rand_word());
    queue_op(deq_pkg::OP_POP_BACK, rand_word());
    queue_op(deq_pkg::OP_SIZE, rand_word());

    // sender holds back until every result has come home
    wait_drained();

    // fill to the top, mostly with pushes at both ends, then hit the full case
    while (gen_live < DEPTH) queue_op(choose_op(88, 4, 0), rand_word());
    queue_op(deq_pkg::OP_PUSH_BACK, rand_word());
    queue_op(deq_pkg::OP_PUSH_FRONT, rand_word());
    queue_op(deq_pkg::OP_SIZE, rand_word());
    queue_op(deq_pkg::OP_FRONT, rand_word());
    queue_op(deq_pkg::OP_BACK, rand_word());
    queue_op(deq_pkg::OP_POP_FRONT, rand_word());
    queue_op(deq_pkg::OP_PUSH_BACK, rand_word());
    queue_op(deq_pkg::OP_PUSH_FRONT, rand_word());
    queue_op(deq_pkg::OP_CLEAR, rand_word());
    queue_op(deq_pkg::OP_PUSH_BACK, rand_word());
    queue_op(deq_pkg::OP_FRONT, rand_word());

    // random segments: push-heavy, pop-heavy or balanced, with the odd clear
    for (int seg = 0; seg < 24; seg++) begin
      mode    = $urandom_range(2);
      seg_len = $urandom_range(20, 60);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          0:       queue_op(choose_op(70, 15, 2), rand_word());
          1:       queue_op(choose_op(20, 65, 2), rand_word());
          default: queue_op(choose_op(45, 40, 2), rand_word());
        endcase
      end
    end

    wait_drained();
    // let any stray result show up
    repeat (20) @(posedge clk);
    if (answers_due.size() != 0) flag_mismatch("results still owed at end of run");
    if (mismatches == 0) begin
      $display("double_ended_queue_core test passed");
    end else begin
      $display("double_ended_queue_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("double_ended_queue_core test failed");
    $finish;
  end

endmodule
